// ----- src/cmaf_pkg.sv -----
// Shared constants, types and controller command bundle for the
// centered moving average filter. No dependencies.
`default_nettype none
package cmaf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = SAMPLE_W + 6;
    localparam int HIST_DEPTH = 128;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int K_W        = 5;
    localparam int CNT_W      = K_W + 1;
    localparam int REM_W      = CNT_W + 1;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [K_W-1:0]    HALF_WIDTH_RESET = K_W'(2);
    localparam logic [ADDR_W-1:0] RCV_SAT          = {ADDR_W{1'b1}};
    localparam logic [CNT_W-1:0]  EMIT_SAT         = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SUM,
        ST_DRAIN,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } cmaf_state_t;

    typedef struct packed {
        logic              wr_en;
        logic              acc_clr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_age;
        logic              div_load;
        logic [CNT_W-1:0]  div_cnt;
        logic              div_step;
    } cmaf_cmd_t;

endpackage
`default_nettype wire

// ----- src/cmaf_in_if.sv -----
// Input sample channel: valid/ready handshake with sample and last flag.
// Depends on cmaf_pkg.
`default_nettype none
interface cmaf_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [cmaf_pkg::SAMPLE_W-1:0] sample;
    logic                               last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

// ----- src/cmaf_out_if.sv -----
// Result channel: valid/ready handshake with smoothed sample and last flag.
// Depends on cmaf_pkg.
`default_nettype none
interface cmaf_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [cmaf_pkg::SAMPLE_W-1:0] smoothed;
    logic                               last_out;

    modport source (output valid, output smoothed, output last_out, input ready);
    modport sink   (input valid, input smoothed, input last_out, output ready);
endinterface
`default_nettype wire

// ----- src/cmaf_datapath.sv -----
// Datapath: sample history memory, window accumulator and serial
// rounding divider. Driven by cmaf_ctrl commands; depends on cmaf_pkg.
`default_nettype none
module cmaf_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire cmaf_pkg::cmaf_cmd_t                  cmd,
    input  wire logic signed [cmaf_pkg::SAMPLE_W-1:0] sample,
    output logic signed [cmaf_pkg::SAMPLE_W-1:0]      smoothed
);
    localparam int SW = cmaf_pkg::SAMPLE_W;
    localparam int UW = cmaf_pkg::SUM_W;
    localparam int AW = cmaf_pkg::ADDR_W;
    localparam int CW = cmaf_pkg::CNT_W;

    logic signed [SW-1:0] mem [cmaf_pkg::HIST_DEPTH];
    logic [AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]        rd_addr;
    logic signed [SW-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic signed [UW-1:0] acc_reg, acc_next;
    logic [UW-1:0]        mag;
    logic [UW-1:0]        quo_reg, quo_next;
    logic [CW:0]          rem_reg, rem_next;
    logic [CW:0]          rem_sh;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;

    assign rd_addr     = wr_ptr_reg - AW'(1) - cmd.rd_age;
    assign wr_ptr_next = cmd.wr_en ? wr_ptr_reg + AW'(1) : wr_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_ptr_reg] <= sample;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clr)
        begin
            acc_next = '0;
        end
        else if (rd_valid_reg)
        begin
            acc_next = acc_reg + UW'(rd_data_reg);
        end
    end

    assign mag    = acc_reg[UW-1] ? UW'(-acc_reg) : UW'(acc_reg);
    assign rem_sh = {rem_reg[CW-1:0], quo_reg[UW-1]};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (cmd.div_load)
        begin
            neg_next = acc_reg[UW-1];
            quo_next = mag + UW'(cmd.div_cnt >> 1);
            rem_next = '0;
            cnt_next = cmd.div_cnt;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, cnt_reg})
            begin
                rem_next = rem_sh - {1'b0, cnt_reg};
                quo_next = {quo_reg[UW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[UW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_valid_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign smoothed = neg_reg ? SW'(-quo_reg[SW-1:0]) : quo_reg[SW-1:0];

endmodule
`default_nettype wire

// ----- src/cmaf_ctrl.sv -----
// Controller: run counters, window bounds and sequencing of reads,
// division and result handshakes. Depends on cmaf_pkg.
`default_nettype none
module cmaf_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [cmaf_pkg::K_W-1:0]         cfg_wdata,
    input  wire logic                             in_valid,
    input  wire logic                             in_last,
    output logic                                  in_ready,
    output logic                                  out_valid,
    output logic                                  out_last,
    input  wire logic                             out_ready,
    output cmaf_pkg::cmaf_cmd_t                   cmd
);
    localparam int KW = cmaf_pkg::K_W;
    localparam int AW = cmaf_pkg::ADDR_W;
    localparam int CW = cmaf_pkg::CNT_W;
    localparam int RW = cmaf_pkg::REM_W;
    localparam int TW = cmaf_pkg::STEP_W;

    cmaf_pkg::cmaf_state_t state_reg, state_next;
    logic [KW-1:0] hw_reg, hw_next;
    logic [KW-1:0] k_reg, k_next;
    logic [AW-1:0] rcv_reg, rcv_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [CW-1:0] d_reg, d_next;
    logic          short_reg, short_next;
    logic          lastrun_reg, lastrun_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [AW-1:0] age_reg, age_next;
    logic [TW-1:0] step_reg, step_next;

    logic [KW-1:0] k_use;
    logic [AW-1:0] rcv_inc;
    logic [AW-1:0] win;
    logic [AW-1:0] lo_w, hi_w;

    assign k_use   = (rcv_reg == '0) ? hw_reg : k_reg;
    assign rcv_inc = (rcv_reg == cmaf_pkg::RCV_SAT) ? rcv_reg : rcv_reg + AW'(1);
    assign win     = AW'({k_use, 1'b1});

    always_comb
    begin
        if (short_reg)
        begin
            lo_w = lo_reg;
            hi_w = hi_reg;
        end
        else
        begin
            lo_w = (d_reg > CW'(k_reg)) ? AW'(d_reg - CW'(k_reg)) : '0;
            hi_w = (emit_reg < CW'(k_reg)) ? AW'(emit_reg) + AW'(d_reg)
                                           : AW'(d_reg) + AW'(k_reg);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        hw_next      = cfg_we ? cfg_wdata : hw_reg;
        k_next       = k_reg;
        rcv_next     = rcv_reg;
        emit_next    = emit_reg;
        rem_next     = rem_reg;
        d_next       = d_reg;
        short_next   = short_reg;
        lastrun_next = lastrun_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        age_next     = age_reg;
        step_next    = step_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd          = '0;
        cmd.rd_age   = age_reg;
        cmd.div_cnt  = CW'(hi_reg - lo_reg + AW'(1));
        out_last     = lastrun_reg && (rem_reg == RW'(1));

        unique case (state_reg)
            cmaf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.wr_en  = 1'b1;
                    k_next     = k_use;
                    d_next     = {k_use, 1'b0};
                    short_next = 1'b0;
                    if (!in_last)
                    begin
                        rcv_next     = rcv_inc;
                        lastrun_next = 1'b0;
                        if (rcv_inc >= win)
                        begin
                            rem_next   = RW'(1);
                            state_next = cmaf_pkg::ST_SETUP;
                        end
                    end
                    else
                    begin
                        rcv_next     = '0;
                        lastrun_next = 1'b1;
                        state_next   = cmaf_pkg::ST_SETUP;
                        if (rcv_inc < win)
                        begin
                            short_next = 1'b1;
                            lo_next    = '0;
                            hi_next    = rcv_inc - AW'(1);
                            rem_next   = RW'(rcv_inc);
                        end
                        else
                        begin
                            rem_next = RW'(win);
                        end
                    end
                end
            end
            cmaf_pkg::ST_SETUP:
            begin
                cmd.acc_clr = 1'b1;
                lo_next     = lo_w;
                hi_next     = hi_w;
                age_next    = lo_w;
                state_next  = cmaf_pkg::ST_SUM;
            end
            cmaf_pkg::ST_SUM:
            begin
                cmd.rd_en = 1'b1;
                if (age_reg == hi_reg)
                begin
                    state_next = cmaf_pkg::ST_DRAIN;
                end
                else
                begin
                    age_next = age_reg + AW'(1);
                end
            end
            cmaf_pkg::ST_DRAIN:
            begin
                state_next = cmaf_pkg::ST_LOAD;
            end
            cmaf_pkg::ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = cmaf_pkg::ST_DIV;
            end
            cmaf_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == TW'(cmaf_pkg::DIV_STEPS - 1))
                begin
                    state_next = cmaf_pkg::ST_OUT;
                end
                else
                begin
                    step_next = step_reg + TW'(1);
                end
            end
            cmaf_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    rem_next = rem_reg - RW'(1);
                    if (!short_reg)
                    begin
                        emit_next = (emit_reg == cmaf_pkg::EMIT_SAT) ? emit_reg
                                                                     : emit_reg + CW'(1);
                        d_next    = d_reg - CW'(1);
                    end
                    if (rem_reg == RW'(1))
                    begin
                        state_next = cmaf_pkg::ST_IDLE;
                        if (lastrun_reg)
                        begin
                            emit_next = '0;
                        end
                    end
                    else if (!short_reg)
                    begin
                        state_next = cmaf_pkg::ST_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = cmaf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cmaf_pkg::ST_IDLE;
            hw_reg      <= cmaf_pkg::HALF_WIDTH_RESET;
            k_reg       <= '0;
            rcv_reg     <= '0;
            emit_reg    <= '0;
            rem_reg     <= '0;
            d_reg       <= '0;
            short_reg   <= 1'b0;
            lastrun_reg <= 1'b0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            age_reg     <= '0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            hw_reg      <= hw_next;
            k_reg       <= k_next;
            rcv_reg     <= rcv_next;
            emit_reg    <= emit_next;
            rem_reg     <= rem_next;
            d_reg       <= d_next;
            short_reg   <= short_next;
            lastrun_reg <= lastrun_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            age_reg     <= age_next;
            step_reg    <= step_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/centered_moving_average_filter.sv -----
// Top level of the centered moving average filter.
// Depends on cmaf_pkg, cmaf_in_if, cmaf_out_if, cmaf_ctrl, cmaf_datapath.
// Each result: accumulator clear, window-length reads (1..63, one history read per
// cycle), a drain step, divider load and serial division, then the result handshake.
// One request at a time; a last sample flushes up to 63 results, each with its own
// window sum and division; a short run repeats one mean back to back.
// Reset: asynchronous, active low; half_width returns to 2, counts clear.
`default_nettype none
module centered_moving_average_filter (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    cmaf_in_if.sink                          in_ch,
    cmaf_out_if.source                       out_ch,
    input  wire logic                        cfg_we,
    input  wire logic [cmaf_pkg::K_W-1:0]    cfg_wdata
);
    cmaf_pkg::cmaf_cmd_t cmd;

    cmaf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_last  (out_ch.last_out),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    cmaf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sample   (in_ch.sample),
        .smoothed (out_ch.smoothed)
    );

endmodule
`default_nettype wire
